/* design/maob_pkg.sv */
`timescale 1ns / 1ps

package maob_pkg;

   localparam int NOTE_W     = 7;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int SAMPLE_W   = 24;
   localparam int WAVE_W     = 21;
   localparam int VOL_W      = 8;
   localparam int RATIO_W    = 16;
   localparam int INC_W      = 32;
   localparam int CODE_W     = 2;
   localparam int SEMI_W     = 17;
   localparam int PROD_W     = 30;
   localparam int ACC_W      = 32;

   localparam logic [63:0] DETUNE_RESET = 64'h4000_4000_4000_4000;
   localparam logic [31:0] A4_RESET     = 32'd39370534;
   localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
   localparam logic [63:0] WAVE_ONE     = 64'd524288;

   localparam logic [31:0] DIV255_MAGIC = 32'h8080_8081;
   localparam int          DIV255_SHIFT = 39;
   localparam logic [15:0] DIV12_MAGIC  = 16'd171;
   localparam int          DIV12_SHIFT  = 11;

   localparam logic [24:0] SAT_POS = 25'd8388607;
   localparam logic [24:0] SAT_NEG = 25'd8388608;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK     = 2'd0,
      KIND_NOTE_ON  = 2'd1,
      KIND_NOTE_OFF = 2'd2
   } kind_type;

   typedef enum logic [CODE_W-1:0] {
      WAVE_RAMP   = 2'd0,
      WAVE_SINE   = 2'd1,
      WAVE_SQUARE = 2'd2,
      WAVE_SILENT = 2'd3
   } wave_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLUMES_LOW   = 3'd0,
      CSR_VOLUMES_HIGH  = 3'd1,
      CSR_WAVEFORMS     = 3'd2,
      CSR_DETUNE_A      = 3'd3,
      CSR_DETUNE_B      = 3'd4,
      CSR_DETUNE_C      = 3'd5,
      CSR_DETUNE_D      = 3'd6,
      CSR_A4_INCREMENT  = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE,
      ST_PITCH_PREP,
      ST_PITCH_MULT,
      ST_PITCH_LOAD,
      ST_TICK_RUN,
      ST_TICK_DRAIN,
      ST_MIX_ABS,
      ST_MIX_MULT,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic capture;
      logic clear_acc;
      logic find;
      logic push;
      logic remove;
      logic voice_off;
      logic pitch_from_top;
      logic pitch_prep;
      logic pitch_mult;
      logic pitch_load;
      logic issue;
      logic mix_abs;
      logic mix_mult;
      logic load_result;
   } dp_cmd_type;

   typedef struct packed {
      logic voice_enabled;
      logic any_match;
      logic top_empty;
      logic pipe_busy;
   } dp_status_type;

   function automatic logic [SEMI_W-1:0] semitone_ratio(input logic [3:0] semi);
      logic [SEMI_W-1:0] r;
      case (semi)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd69433;
         4'd2:    r = 17'd73562;
         4'd3:    r = 17'd77936;
         4'd4:    r = 17'd82570;
         4'd5:    r = 17'd87480;
         4'd6:    r = 17'd92682;
         4'd7:    r = 17'd98193;
         4'd8:    r = 17'd104032;
         4'd9:    r = 17'd110218;
         4'd10:   r = 17'd116772;
         4'd11:   r = 17'd123715;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

endpackage

/* design/maob_ctrl.sv */
`timescale 1ns / 1ps

module maob_ctrl #(
   parameter int NUM_OSCILLATORS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [maob_pkg::KIND_W-1:0] req_kind,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output maob_pkg::dp_cmd_type        cmd,
   output logic [((NUM_OSCILLATORS > 1) ? $clog2(NUM_OSCILLATORS) : 1)-1:0] osc_index,
   input  maob_pkg::dp_status_type     status
);

   localparam int OSC_IW = (NUM_OSCILLATORS > 1) ? $clog2(NUM_OSCILLATORS) : 1;
   localparam logic [OSC_IW-1:0] OSC_LAST = OSC_IW'(NUM_OSCILLATORS - 1);

   maob_pkg::state_type state_ff, state_in;
   maob_pkg::kind_type  kind_ff, kind_in;
   maob_pkg::kind_type  req_kind_code;
   logic [OSC_IW-1:0]   osc_cnt_ff, osc_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   assign req_kind_code = maob_pkg::kind_type'(req_kind);
   assign rsp_valid     = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= maob_pkg::ST_IDLE;
         kind_ff      <= maob_pkg::KIND_TICK;
         osc_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         osc_cnt_ff   <= osc_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      osc_cnt_in   = osc_cnt_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      req_stall    = 1'b1;
      cmd          = '0;
      osc_index    = osc_cnt_ff;

      case (state_ff)
         maob_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               kind_in     = req_kind_code;
               case (req_kind_code)
                  maob_pkg::KIND_TICK: begin
                     cmd.clear_acc = 1'b1;
                     osc_cnt_in    = '0;
                     state_in      = status.voice_enabled ? maob_pkg::ST_TICK_RUN
                                                          : maob_pkg::ST_MIX_ABS;
                  end
                  maob_pkg::KIND_NOTE_ON, maob_pkg::KIND_NOTE_OFF: begin
                     state_in = maob_pkg::ST_MATCH;
                  end
                  default: begin
                     state_in = maob_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         maob_pkg::ST_MATCH: begin
            cmd.find = 1'b1;
            state_in = maob_pkg::ST_UPDATE;
         end
         maob_pkg::ST_UPDATE: begin
            if (kind_ff == maob_pkg::KIND_NOTE_ON) begin
               cmd.push = ~status.any_match;
            end else begin
               cmd.remove = status.any_match;
            end
            state_in = maob_pkg::ST_PITCH_PREP;
         end
         maob_pkg::ST_PITCH_PREP: begin
            cmd.pitch_from_top = (kind_ff == maob_pkg::KIND_NOTE_OFF);
            if ((kind_ff == maob_pkg::KIND_NOTE_OFF) && status.top_empty) begin
               cmd.voice_off = 1'b1;
               state_in      = maob_pkg::ST_IDLE;
            end else begin
               cmd.pitch_prep = 1'b1;
               state_in       = maob_pkg::ST_PITCH_MULT;
            end
         end
         maob_pkg::ST_PITCH_MULT: begin
            cmd.pitch_mult = 1'b1;
            state_in       = maob_pkg::ST_PITCH_LOAD;
         end
         maob_pkg::ST_PITCH_LOAD: begin
            cmd.pitch_load = 1'b1;
            state_in       = maob_pkg::ST_IDLE;
         end
         maob_pkg::ST_TICK_RUN: begin
            cmd.issue = 1'b1;
            if (osc_cnt_ff == OSC_LAST) begin
               state_in = maob_pkg::ST_TICK_DRAIN;
            end else begin
               osc_cnt_in = osc_cnt_ff + OSC_IW'(1);
            end
         end
         maob_pkg::ST_TICK_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = maob_pkg::ST_MIX_ABS;
            end
         end
         maob_pkg::ST_MIX_ABS: begin
            cmd.mix_abs = 1'b1;
            state_in    = maob_pkg::ST_MIX_MULT;
         end
         maob_pkg::ST_MIX_MULT: begin
            cmd.mix_mult = 1'b1;
            state_in     = maob_pkg::ST_RESULT;
         end
         maob_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_result = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = maob_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = maob_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* design/maob_dpath.sv */
`timescale 1ns / 1ps

module maob_dpath #(
   parameter int NUM_OSCILLATORS  = 16,
   parameter int STACK_DEPTH      = 16,
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int PHASE_BITS       = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [maob_pkg::NOTE_W-1:0]        req_note_number,
   input  logic                               csr_write,
   input  logic [maob_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [maob_pkg::CSR_DATA_W-1:0]    csr_data,
   input  maob_pkg::dp_cmd_type               cmd,
   input  logic [((NUM_OSCILLATORS > 1) ? $clog2(NUM_OSCILLATORS) : 1)-1:0] osc_index,
   output maob_pkg::dp_status_type            status,
   output logic signed [maob_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                               rsp_voice_active
);

   localparam int OSC_IW  = (NUM_OSCILLATORS > 1) ? $clog2(NUM_OSCILLATORS) : 1;
   localparam int SINE_AW = $clog2(SINE_TABLE_DEPTH);
   localparam int INC_LSB = 46 - PHASE_BITS;
   localparam int WAVE_W  = maob_pkg::WAVE_W;
   localparam int NOTE_W  = maob_pkg::NOTE_W;
   localparam int PROD_W  = maob_pkg::PROD_W;
   localparam int ACC_W   = maob_pkg::ACC_W;

   function automatic logic signed [WAVE_W-1:0] sine_entry(input int unsigned k);
      logic [63:0] t;
      logic [63:0] u;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      logic [1:0]  quad;
      t    = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
      quad = t[31:30];
      u    = {34'd0, t[29:0]};
      if (quad[0]) begin
         u = 64'h4000_0000 - u;
      end
      x    = (u * maob_pkg::HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - term;
      v    = (sum + 64'd1024) >> 11;
      if (v > maob_pkg::WAVE_ONE) begin
         v = maob_pkg::WAVE_ONE;
      end
      return quad[1] ? -WAVE_W'(v) : WAVE_W'(v);
   endfunction

   // Configuration registers.
   logic [63:0] vol_low_ff, vol_high_ff;
   logic [31:0] codes_ff;
   logic [63:0] detune_a_ff, detune_b_ff, detune_c_ff, detune_d_ff;
   logic [31:0] a4_inc_ff;

   // Voice state.
   logic [NOTE_W-1:0]     held_ff [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] match_ff;
   logic [STACK_DEPTH-1:0] shift_up;
   logic                  voice_en_ff;
   logic [31:0]           base_inc_ff;
   logic [PHASE_BITS-1:0] osc_phase_ff [NUM_OSCILLATORS];
   logic [NOTE_W-1:0]     note_ff;

   // Pitch unit.
   logic [NOTE_W-1:0] pitch_note;
   logic [7:0]        pitch_d;
   logic [15:0]       pitch_scaled;
   logic [3:0]        pitch_oct;
   logic [7:0]        pitch_rem;
   logic [3:0]        oct_ff;
   logic [3:0]        semi_ff;
   logic [48:0]       pitch_prod_ff;
   logic [4:0]        pitch_shift;
   logic [49:0]       pitch_sum;
   logic [49:0]       pitch_shifted;
   logic [31:0]       pitch_sat;

   // Oscillator pipeline.
   logic [maob_pkg::VOL_W-1:0]   vol_arr   [NUM_OSCILLATORS];
   logic [maob_pkg::RATIO_W-1:0] ratio_arr [NUM_OSCILLATORS];
   logic [maob_pkg::CODE_W-1:0]  code_arr  [NUM_OSCILLATORS];
   logic [127:0]                 volumes;
   logic [255:0]                 ratios;

   logic signed [WAVE_W-1:0] sine_rom [SINE_TABLE_DEPTH];

   logic                         a_v_ff;
   logic [OSC_IW-1:0]            a_idx_ff;
   logic [PHASE_BITS-1:0]        a_phase_ff;
   logic [maob_pkg::CODE_W-1:0]  a_code_ff;
   logic [maob_pkg::VOL_W-1:0]   a_vol_ff;
   logic [maob_pkg::RATIO_W-1:0] a_ratio_ff;
   logic [31:0]                  a_p32;
   logic [44:0]                  a_sine_scaled;
   logic [SINE_AW-1:0]           a_sine_addr;

   logic                         b_v_ff;
   logic [OSC_IW-1:0]            b_idx_ff;
   logic [PHASE_BITS-1:0]        b_phase_ff;
   logic [maob_pkg::CODE_W-1:0]  b_code_ff;
   logic [maob_pkg::VOL_W-1:0]   b_vol_ff;
   logic signed [WAVE_W-1:0]     b_rom_ff;
   logic [47:0]                  b_inc_ff;
   logic [31:0]                  b_p32;
   logic signed [WAVE_W-1:0]     b_wave;

   logic                         c_v_ff;
   logic signed [PROD_W-1:0]     c_prod_ff;
   logic signed [ACC_W-1:0]      acc_ff;

   // Mixer output.
   logic [31:0]             mag_ff;
   logic                    neg_ff;
   logic [63:0]             div_prod_ff;
   logic [24:0]             quot;
   logic [maob_pkg::SAMPLE_W-1:0] sample_in;
   logic signed [maob_pkg::SAMPLE_W-1:0] sample_ff;
   logic                    active_ff;

   for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sine
      localparam logic signed [WAVE_W-1:0] SINE_VAL = sine_entry(k);
      assign sine_rom[k] = SINE_VAL;
   end

   assign volumes = {vol_high_ff, vol_low_ff};
   assign ratios  = {detune_d_ff, detune_c_ff, detune_b_ff, detune_a_ff};

   always_comb begin
      for (int i = 0; i < NUM_OSCILLATORS; i++) begin
         vol_arr[i]   = volumes[8*i +: 8];
         ratio_arr[i] = ratios[16*i +: 16];
         code_arr[i]  = codes_ff[2*i +: 2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_low_ff  <= '0;
         vol_high_ff <= '0;
         codes_ff    <= '0;
         detune_a_ff <= maob_pkg::DETUNE_RESET;
         detune_b_ff <= maob_pkg::DETUNE_RESET;
         detune_c_ff <= maob_pkg::DETUNE_RESET;
         detune_d_ff <= maob_pkg::DETUNE_RESET;
         a4_inc_ff   <= maob_pkg::A4_RESET;
      end else if (csr_write) begin
         case (maob_pkg::csr_index_type'(csr_index))
            maob_pkg::CSR_VOLUMES_LOW:  vol_low_ff  <= csr_data;
            maob_pkg::CSR_VOLUMES_HIGH: vol_high_ff <= csr_data;
            maob_pkg::CSR_WAVEFORMS:    codes_ff    <= csr_data[31:0];
            maob_pkg::CSR_DETUNE_A:     detune_a_ff <= csr_data;
            maob_pkg::CSR_DETUNE_B:     detune_b_ff <= csr_data;
            maob_pkg::CSR_DETUNE_C:     detune_c_ff <= csr_data;
            maob_pkg::CSR_DETUNE_D:     detune_d_ff <= csr_data;
            maob_pkg::CSR_A4_INCREMENT: a4_inc_ff   <= csr_data[31:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         note_ff <= req_note_number;
      end
   end

   // A note-off removes the deepest matching slot: that slot and every
   // slot below it move up by one.
   always_comb begin
      logic [STACK_DEPTH-1:0] high_mask;
      for (int i = 0; i < STACK_DEPTH; i++) begin
         high_mask   = STACK_DEPTH'({STACK_DEPTH{1'b1}} << (i + 1));
         shift_up[i] = (|match_ff) & ((match_ff & high_mask) == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STACK_DEPTH; i++) begin
            held_ff[i] <= '0;
         end
         match_ff    <= '0;
         voice_en_ff <= 1'b0;
      end else begin
         if (cmd.find) begin
            for (int i = 0; i < STACK_DEPTH; i++) begin
               match_ff[i] <= (held_ff[i] == note_ff);
            end
         end
         if (cmd.push) begin
            held_ff[0] <= note_ff;
            for (int i = 1; i < STACK_DEPTH; i++) begin
               held_ff[i] <= held_ff[i-1];
            end
            voice_en_ff <= 1'b1;
         end else if (cmd.remove) begin
            for (int i = 0; i < STACK_DEPTH - 1; i++) begin
               if (shift_up[i]) begin
                  held_ff[i] <= held_ff[i+1];
               end
            end
            if (shift_up[STACK_DEPTH-1]) begin
               held_ff[STACK_DEPTH-1] <= '0;
            end
         end
         if (cmd.voice_off) begin
            voice_en_ff <= 1'b0;
         end
      end
   end

   assign pitch_note   = cmd.pitch_from_top ? held_ff[0] : note_ff;
   assign pitch_d      = 8'(pitch_note) + 8'd3;
   assign pitch_scaled = 16'(pitch_d) * maob_pkg::DIV12_MAGIC;
   assign pitch_oct    = pitch_scaled[maob_pkg::DIV12_SHIFT +: 4];
   assign pitch_rem    = pitch_d - 8'(pitch_oct) * 8'd12;

   assign pitch_shift   = 5'd22 - 5'(oct_ff);
   assign pitch_sum     = 50'(pitch_prod_ff) + (50'(1) << (pitch_shift - 5'd1));
   assign pitch_shifted = pitch_sum >> pitch_shift;
   assign pitch_sat     = (|pitch_shifted[49:32]) ? 32'hFFFF_FFFF : pitch_shifted[31:0];

   always_ff @(posedge clock) begin
      if (cmd.pitch_prep) begin
         oct_ff  <= pitch_oct;
         semi_ff <= pitch_rem[3:0];
      end
      if (cmd.pitch_mult) begin
         pitch_prod_ff <= 49'(a4_inc_ff) * 49'(maob_pkg::semitone_ratio(semi_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_inc_ff <= '0;
      end else if (cmd.pitch_load) begin
         base_inc_ff <= pitch_sat;
      end
   end

   assign a_p32         = 32'(a_phase_ff) << (32 - PHASE_BITS);
   assign a_sine_scaled = 45'(a_p32) * 45'(SINE_TABLE_DEPTH);
   assign a_sine_addr   = a_sine_scaled[32 +: SINE_AW];
   assign b_p32         = 32'(b_phase_ff) << (32 - PHASE_BITS);

   always_comb begin
      case (maob_pkg::wave_type'(b_code_ff))
         maob_pkg::WAVE_RAMP:   b_wave = WAVE_W'(b_p32[31:13]);
         maob_pkg::WAVE_SINE:   b_wave = b_rom_ff;
         maob_pkg::WAVE_SQUARE: b_wave = b_p32[31] ? WAVE_W'(maob_pkg::WAVE_ONE)
                                                   : -WAVE_W'(maob_pkg::WAVE_ONE);
         default:               b_wave = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else begin
         a_v_ff <= cmd.issue;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_idx_ff   <= osc_index;
      a_phase_ff <= osc_phase_ff[osc_index];
      a_code_ff  <= code_arr[osc_index];
      a_vol_ff   <= vol_arr[osc_index];
      a_ratio_ff <= ratio_arr[osc_index];

      b_idx_ff   <= a_idx_ff;
      b_phase_ff <= a_phase_ff;
      b_code_ff  <= a_code_ff;
      b_vol_ff   <= a_vol_ff;
      b_rom_ff   <= sine_rom[a_sine_addr];
      b_inc_ff   <= 48'(base_inc_ff) * 48'(a_ratio_ff);

      c_prod_ff  <= PROD_W'($signed({1'b0, b_vol_ff})) * PROD_W'(b_wave);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_OSCILLATORS; i++) begin
            osc_phase_ff[i] <= '0;
         end
      end else if (b_v_ff) begin
         osc_phase_ff[b_idx_ff] <= b_phase_ff + b_inc_ff[45:INC_LSB];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_acc) begin
         acc_ff <= '0;
      end else if (c_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(c_prod_ff);
      end
   end

   assign quot = div_prod_ff[maob_pkg::DIV255_SHIFT +: 25];

   always_comb begin
      if (neg_ff) begin
         sample_in = (quot > maob_pkg::SAT_NEG) ? 24'h80_0000 : 24'(-quot);
      end else begin
         sample_in = (quot > maob_pkg::SAT_POS) ? 24'h7F_FFFF : quot[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mix_abs) begin
         mag_ff <= (acc_ff[ACC_W-1] ? 32'(-acc_ff) : 32'(acc_ff)) + 32'd127;
         neg_ff <= acc_ff[ACC_W-1];
      end
      if (cmd.mix_mult) begin
         div_prod_ff <= 64'(mag_ff) * 64'(maob_pkg::DIV255_MAGIC);
      end
      if (cmd.load_result) begin
         sample_ff <= sample_in;
         active_ff <= voice_en_ff;
      end
   end

   assign rsp_sample       = sample_ff;
   assign rsp_voice_active = active_ff;

   assign status.voice_enabled = voice_en_ff;
   assign status.any_match     = |match_ff;
   assign status.top_empty     = (held_ff[0] == '0);
   assign status.pipe_busy     = a_v_ff | b_v_ff | c_v_ff;

endmodule

/* design/mono_additive_oscillator_bank.sv */
`timescale 1ns / 1ps

// Monophonic additive voice with a last-note-priority note stack and a bank of
// phase-accumulator oscillators mixed into one saturated Q4.19 sample per tick.
// One transaction is handled at a time. In a tick with the voice on, the
// oscillators go one per cycle through a shared pipeline of increment
// multiply, sine lookup and volume multiply-accumulate, followed by the
// pipeline drain and the divide by 255 of the mix. A tick with the voice off
// goes straight to the divide, and a note-off that empties the stack turns
// the voice off with no pitch update. A new transaction is taken while the
// previous sample still waits in the output register; the tick then holds
// in its result state until that register is free. The configuration port is
// always ready and must only be written while the block is idle.
module mono_additive_oscillator_bank #(
   parameter int NUM_OSCILLATORS  = 16,
   parameter int STACK_DEPTH      = 16,
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int PHASE_BITS       = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [maob_pkg::KIND_W-1:0]          req_kind,
   input  logic [maob_pkg::NOTE_W-1:0]          req_note_number,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [maob_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                                 rsp_voice_active,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [maob_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [maob_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int OSC_IW = (NUM_OSCILLATORS > 1) ? $clog2(NUM_OSCILLATORS) : 1;

   maob_pkg::dp_cmd_type    cmd;
   maob_pkg::dp_status_type status;
   logic [OSC_IW-1:0]       osc_index;

   assign csr_ready = 1'b1;

   maob_ctrl #(
      .NUM_OSCILLATORS (NUM_OSCILLATORS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .osc_index (osc_index),
      .status    (status)
   );

   maob_dpath #(
      .NUM_OSCILLATORS  (NUM_OSCILLATORS),
      .STACK_DEPTH      (STACK_DEPTH),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .PHASE_BITS       (PHASE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_note_number  (req_note_number),
      .csr_write        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .osc_index        (osc_index),
      .status           (status),
      .rsp_sample       (rsp_sample),
      .rsp_voice_active (rsp_voice_active)
   );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int STACK_SIZE = 16;
   localparam int OSC_COUNT = 16;
   localparam int SINE_DEPTH = 1024;
   localparam int WAVE_FULL = 524288;
   localparam longint unsigned HALF_PI = 64'd1686629713;
   localparam logic [63:0] UNITY_RATIOS = 64'h4000_4000_4000_4000;
   localparam logic [31:0] A4_DEFAULT = 32'd39370534;
   localparam logic [maob_pkg::KIND_W-1:0] KIND_IGNORED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT = 20000;
   localparam int TIMEOUT_NS = 2000000;

   typedef struct packed {
      logic signed [maob_pkg::SAMPLE_W-1:0] sample;
      logic active;
   } tick_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [maob_pkg::KIND_W-1:0] req_kind = maob_pkg::KIND_TICK;
   logic [maob_pkg::NOTE_W-1:0] req_note_number = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [maob_pkg::SAMPLE_W-1:0] rsp_sample;
   logic rsp_voice_active;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [maob_pkg::CSR_IDX_W-1:0] csr_index = maob_pkg::CSR_VOLUMES_LOW;
   logic [maob_pkg::CSR_DATA_W-1:0] csr_data = '0;

   logic [63:0] gain_lo;
   logic [63:0] gain_hi;
   logic [31:0] wave_sel;
   logic [63:0] detune_ratio [4];
   logic [31:0] a4_step;
   logic [6:0] note_stack [STACK_SIZE];
   logic voice_on;
   logic [31:0] base_step;
   logic [31:0] osc_angle [OSC_COUNT];
   int sine_q19 [SINE_DEPTH];

   tick_result_type pending_samples[$];
   int mismatch_count = 0;
   int items_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;

   mono_additive_oscillator_bank dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_note_number(req_note_number),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample(rsp_sample),
      .rsp_voice_active(rsp_voice_active),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   function automatic int sine_sample(input int k);
      longint unsigned kk, t, quad, u, x, x2, term, sum, v;
      int j;
      kk = k;
      t = (kk << 32) / SINE_DEPTH;
      quad = (t >> 30) & 64'd3;
      u = t & 64'h3FFF_FFFF;
      if (quad[0]) begin
         u = (64'd1 << 30) - u;
      end
      x = (u * HALF_PI) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (j = 1; j <= 7; j++) begin
         term = ((term * x2) >> 30) / longint'(2 * j * (2 * j + 1));
         if (j % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      v = (sum + 64'd1024) >> 11;
      if (v > WAVE_FULL) begin
         v = WAVE_FULL;
      end
      return (quad >= 2) ? -int'(v) : int'(v);
   endfunction

   function automatic longint unsigned semitone_q16(input int s);
      case (s)
         0: return 65536;
         1: return 69433;
         2: return 73562;
         3: return 77936;
         4: return 82570;
         5: return 87480;
         6: return 92682;
         7: return 98193;
         8: return 104032;
         9: return 110218;
         10: return 116772;
         default: return 123715;
      endcase
   endfunction

   function automatic logic [31:0] pitch_step(input logic [6:0] note);
      int unsigned d, sh;
      longint unsigned a4, prod, r;
      d = note;
      d = d + 3;
      sh = 22 - d / 12;
      a4 = a4_step;
      prod = a4 * semitone_q16(d % 12);
      r = (prod + (64'd1 << (sh - 1))) >> sh;
      return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
   endfunction

   function automatic void reset_model();
      int i;
      gain_lo = '0;
      gain_hi = '0;
      wave_sel = '0;
      for (i = 0; i < 4; i++) begin
         detune_ratio[i] = UNITY_RATIOS;
      end
      a4_step = A4_DEFAULT;
      for (i = 0; i < STACK_SIZE; i++) begin
         note_stack[i] = '0;
      end
      voice_on = 1'b0;
      base_step = '0;
      for (i = 0; i < OSC_COUNT; i++) begin
         osc_angle[i] = '0;
      end
      for (i = 0; i < SINE_DEPTH; i++) begin
         sine_q19[i] = sine_sample(i);
      end
   endfunction

   function automatic void press_note(input logic [6:0] note);
      int i;
      base_step = pitch_step(note);
      for (i = 0; i < STACK_SIZE; i++) begin
         if (note_stack[i] == note) begin
            return;
         end
      end
      for (i = STACK_SIZE - 1; i > 0; i--) begin
         note_stack[i] = note_stack[i - 1];
      end
      note_stack[0] = note;
      voice_on = 1'b1;
   endfunction

   function automatic void release_note(input logic [6:0] note);
      int i, pos;
      pos = -1;
      for (i = 0; i < STACK_SIZE; i++) begin
         if (note_stack[i] == note) begin
            pos = i;
         end
      end
      if (pos >= 0) begin
         for (i = pos; i < STACK_SIZE - 1; i++) begin
            note_stack[i] = note_stack[i + 1];
         end
         note_stack[STACK_SIZE - 1] = '0;
      end
      if (note_stack[0] == 0) begin
         voice_on = 1'b0;
      end else begin
         base_step = pitch_step(note_stack[0]);
      end
   endfunction

   function automatic logic signed [maob_pkg::SAMPLE_W-1:0] mix_tick();
      longint acc, vol, res;
      longint unsigned step64, ratio, inc, mag, q;
      logic [31:0] p;
      int wave, i;
      if (!voice_on) begin
         return '0;
      end
      acc = 0;
      step64 = base_step;
      for (i = 0; i < OSC_COUNT; i++) begin
         p = osc_angle[i];
         vol = (i < 8) ? ((gain_lo >> (8 * i)) & 64'hFF)
                       : ((gain_hi >> (8 * (i - 8))) & 64'hFF);
         ratio = (detune_ratio[i / 4] >> (16 * (i % 4))) & 64'hFFFF;
         case (maob_pkg::wave_type'((wave_sel >> (2 * i)) & 32'd3))
            maob_pkg::WAVE_RAMP: wave = int'(p >> 13);
            maob_pkg::WAVE_SINE: wave = sine_q19[p[31:22]];
            maob_pkg::WAVE_SQUARE: wave = (p < 32'h8000_0000) ? -WAVE_FULL : WAVE_FULL;
            default: wave = 0;
         endcase
         acc = acc + vol * longint'(wave);
         inc = (step64 * ratio) >> 14;
         osc_angle[i] = osc_angle[i] + inc[31:0];
      end
      mag = (acc < 0) ? -acc : acc;
      q = (mag + 64'd127) / 64'd255;
      if (acc < 0) begin
         res = (q > 64'd8388608) ? -64'sd8388608 : -longint'(q);
      end else begin
         res = (q > 64'd8388607) ? 64'sd8388607 : longint'(q);
      end
      return res[maob_pkg::SAMPLE_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("tb: mismatch at %0t: %s", $time, what);
   endtask

   task automatic check_sample();
      tick_result_type want;
      if (pending_samples.size() == 0) begin
         report_mismatch($sformatf("unexpected sample %0d", rsp_sample));
         return;
      end
      want = pending_samples.pop_front();
      if (rsp_sample !== want.sample) begin
         report_mismatch($sformatf("sample %0d, expected %0d", rsp_sample, want.sample));
      end
      if (rsp_voice_active !== want.active) begin
         report_mismatch($sformatf("voice_active %b, expected %b", rsp_voice_active,
            want.active));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         check_sample();
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_event(input logic [maob_pkg::KIND_W-1:0] kind,
                             input logic [maob_pkg::NOTE_W-1:0] note);
      tick_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_note_number <= note;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
      case (kind)
         maob_pkg::KIND_TICK: begin
            r.sample = mix_tick();
            r.active = voice_on;
            pending_samples.push_back(r);
         end
         maob_pkg::KIND_NOTE_ON: press_note(note);
         maob_pkg::KIND_NOTE_OFF: release_note(note);
         default: ;
      endcase
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_samples.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_samples.size() != 0) begin
         report_mismatch($sformatf("%0d samples never arrived", pending_samples.size()));
         pending_samples.delete();
      end
   endtask

   task automatic csr_write(input maob_pkg::csr_index_type idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (idx)
         maob_pkg::CSR_VOLUMES_LOW: gain_lo = value;
         maob_pkg::CSR_VOLUMES_HIGH: gain_hi = value;
         maob_pkg::CSR_WAVEFORMS: wave_sel = value[31:0];
         maob_pkg::CSR_DETUNE_A: detune_ratio[0] = value;
         maob_pkg::CSR_DETUNE_B: detune_ratio[1] = value;
         maob_pkg::CSR_DETUNE_C: detune_ratio[2] = value;
         maob_pkg::CSR_DETUNE_D: detune_ratio[3] = value;
         default: a4_step = value[31:0];
      endcase
      @(posedge clock);
   endtask

   task automatic load_config(input logic [63:0] v_lo, input logic [63:0] v_hi,
                              input logic [63:0] waves, input logic [63:0] da,
                              input logic [63:0] db, input logic [63:0] dc,
                              input logic [63:0] dd, input logic [63:0] a4);
      drain();
      csr_write(maob_pkg::CSR_VOLUMES_LOW, v_lo);
      csr_write(maob_pkg::CSR_VOLUMES_HIGH, v_hi);
      csr_write(maob_pkg::CSR_WAVEFORMS, waves);
      csr_write(maob_pkg::CSR_DETUNE_A, da);
      csr_write(maob_pkg::CSR_DETUNE_B, db);
      csr_write(maob_pkg::CSR_DETUNE_C, dc);
      csr_write(maob_pkg::CSR_DETUNE_D, dd);
      csr_write(maob_pkg::CSR_A4_INCREMENT, a4);
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] near_unity();
      logic [63:0] r;
      int lane;
      r = '0;
      for (lane = 0; lane < 4; lane++) begin
         r = r | (64'(16'h3C00 + $urandom_range(0, 16'h0800)) << (16 * lane));
      end
      return r;
   endfunction

   function automatic logic [6:0] pick_note();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) begin
         return 7'd0;
      end else if (roll < 16) begin
         return 7'd127;
      end else if (roll < 50) begin
         return 7'($urandom_range(60, 71));
      end
      return 7'($urandom_range(0, 127));
   endfunction

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   task automatic test_silent_voice();
      send_event(maob_pkg::KIND_TICK, 7'd127);
      send_event(maob_pkg::KIND_NOTE_OFF, 7'd9);
      send_event(KIND_IGNORED, 7'd127);
      send_event(maob_pkg::KIND_NOTE_ON, 7'd0);
      send_event(maob_pkg::KIND_TICK, 7'd0);
   endtask

   task automatic test_note_edges();
      load_config(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
         {$urandom, 32'hE4E4_E4E4}, UNITY_RATIOS, UNITY_RATIOS, UNITY_RATIOS,
         UNITY_RATIOS, {$urandom, A4_DEFAULT});
      send_event(maob_pkg::KIND_NOTE_ON, 7'd127);
      send_event(maob_pkg::KIND_TICK, 7'd0);
      send_event(maob_pkg::KIND_NOTE_ON, 7'd127);
      send_event(maob_pkg::KIND_NOTE_ON, 7'd0);
      send_event(maob_pkg::KIND_TICK, 7'd0);
      send_event(maob_pkg::KIND_NOTE_ON, 7'd69);
      send_event(maob_pkg::KIND_TICK, 7'd0);
      send_event(maob_pkg::KIND_NOTE_OFF, 7'd5);
      send_event(maob_pkg::KIND_TICK, 7'd0);
      send_event(maob_pkg::KIND_NOTE_OFF, 7'd69);
      send_event(maob_pkg::KIND_NOTE_OFF, 7'd127);
      send_event(maob_pkg::KIND_TICK, 7'd0);
   endtask

   task automatic test_stack_overflow();
      int n;
      for (n = 100; n <= 116; n++) begin
         send_event(maob_pkg::KIND_NOTE_ON, 7'(n));
      end
      send_event(maob_pkg::KIND_NOTE_ON, 7'd0);
      send_event(maob_pkg::KIND_TICK, 7'd0);
      send_event(maob_pkg::KIND_NOTE_OFF, 7'd0);
      send_event(maob_pkg::KIND_TICK, 7'd0);
      send_event(maob_pkg::KIND_NOTE_OFF, 7'd100);
   endtask

   task automatic test_backpressure();
      int n;
      load_config(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
         {$urandom, 32'hAAAA_AAAA}, UNITY_RATIOS, UNITY_RATIOS, UNITY_RATIOS,
         UNITY_RATIOS, {$urandom, A4_DEFAULT});
      set_idling(0, 0);
      @(negedge clock);
      hold_left = 300;
      @(posedge clock);
      for (n = 0; n < 30; n++) begin
         if ($urandom_range(3) == 0) begin
            send_event(maob_pkg::KIND_NOTE_ON, pick_note());
         end else begin
            send_event(maob_pkg::KIND_TICK, 7'($urandom));
         end
      end
   endtask

   task automatic run_random_traffic(input int count);
      int stop_at, roll, guard, burst;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 46) begin
            send_event(maob_pkg::KIND_TICK, 7'($urandom));
         end else if (roll < 70) begin
            send_event(maob_pkg::KIND_NOTE_ON, pick_note());
         end else if (roll < 88) begin
            if ($urandom_range(3) != 0) begin
               send_event(maob_pkg::KIND_NOTE_OFF, note_stack[$urandom_range(3)]);
            end else begin
               send_event(maob_pkg::KIND_NOTE_OFF, pick_note());
            end
         end else if (roll < 91) begin
            send_event(KIND_IGNORED, 7'($urandom));
         end else if (roll < 96) begin
            burst = $urandom_range(6, 18);
            repeat (burst) send_event(maob_pkg::KIND_NOTE_ON, pick_note());
            send_event(maob_pkg::KIND_TICK, 7'($urandom));
         end else begin
            guard = 0;
            while (note_stack[0] != 0 && guard < STACK_SIZE) begin
               send_event(maob_pkg::KIND_NOTE_OFF, note_stack[0]);
               guard++;
            end
            send_event(maob_pkg::KIND_TICK, 7'($urandom));
         end
      end
   endtask

   task automatic test_random_steady();
      load_config(random_word(), random_word(), random_word(), near_unity(), near_unity(),
         near_unity(), near_unity(), {$urandom, 32'($urandom_range(20000000, 80000000))});
      set_idling(0, 0);
      run_random_traffic(90);
   endtask

   task automatic test_random_sender_gaps();
      load_config(random_word(), random_word(), random_word(), random_word(), random_word(),
         random_word(), random_word(), random_word());
      set_idling(54, 0);
      run_random_traffic(90);
   endtask

   task automatic test_random_receiver_stalls();
      load_config(random_word(), random_word(), random_word(), 64'hFFFF_FFFF_FFFF_FFFF,
         64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
         64'hFFFF_FFFF_FFFF_FFFF);
      set_idling(0, 54);
      run_random_traffic(90);
   endtask

   task automatic test_random_both_idle();
      load_config(random_word(), random_word(), random_word(), near_unity(), random_word(),
         near_unity(), random_word(), {$urandom, 32'($urandom_range(1000000, 400000000))});
      set_idling(19, 19);
      run_random_traffic(90);
   endtask

   task automatic test_zero_config();
      load_config('0, '0, '0, '0, '0, '0, '0, '0);
      set_idling(19, 19);
      run_random_traffic(25);
   endtask

   initial begin
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_silent_voice();
      test_note_edges();
      test_stack_overflow();
      test_backpressure();
      test_random_steady();
      test_random_sender_gaps();
      test_random_receiver_stalls();
      test_random_both_idle();
      test_zero_config();
      drain();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule
